@@ rtl/rss_pkg.sv @@
// shared types for the record selection sorter
package rss_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_SCAN,
    ST_SWAP_LOW,
    ST_SWAP_POS,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

endpackage

@@ rtl/rss_ram.sv @@
// generic single write port ram with registered read
module rss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/record_selection_sort.sv @@
// Record selection sorter. Records (16-bit key, 8-bit tag) are loaded one per cycle into
// a store of CAPACITY entries while in_ready is high; a record arriving with the store full
// is dropped and the set is flagged overflowed. The record marked is_final starts an in-place
// ascending selection sort that keeps the first strictly smaller minimum of each pass and
// swaps it into place. One compare unit scans the store through a single read port: for n
// stored records there are n - 1 passes, each a read, a scan and two swap writes; each
// sorted record is then read, registered and held until the sink takes it, the last one
// with end_of_set. The input is not ready from the final record until the last result
// transfer. The store has no reset; only entries written in the current set are read.
module record_selection_sort #(
  parameter int CAPACITY = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rss_pkg::KEY_W-1:0] key_value,
  input  logic [rss_pkg::TAG_W-1:0] record_tag,
  input  logic                     is_final,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [rss_pkg::KEY_W-1:0] sorted_key,
  output logic [rss_pkg::TAG_W-1:0] sorted_tag,
  output logic                     end_of_set,
  output logic                     overflowed
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  rss_pkg::state_t state, state_next;

  logic [CW-1:0] fill, fill_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] k, k_next;
  logic [AW-1:0] low, low_next;
  rss_pkg::entry_t min_e, min_next;
  rss_pkg::entry_t cur_e, cur_next;
  logic          out_valid_next;
  logic [rss_pkg::KEY_W-1:0] out_key_next;
  logic [rss_pkg::TAG_W-1:0] out_tag_next;
  logic          out_end_next;
  logic          out_ovf_next;

  logic          we;
  logic [AW-1:0] waddr;
  rss_pkg::entry_t wdata;
  logic [AW-1:0] raddr;
  rss_pkg::entry_t rdata;
  logic [CW-1:0] j_prev;

  assign in_ready = (state == rss_pkg::ST_LOAD);
  assign j_prev   = j - ONE;

  // record store
  rss_ram #(
    .WIDTH($bits(rss_pkg::entry_t)),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rss_pkg::ST_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
  end

  // sort counters and working records
  always_ff @(posedge clk) begin
    n          <= n_next;
    i          <= i_next;
    j          <= j_next;
    k          <= k_next;
    low        <= low_next;
    min_e      <= min_next;
    cur_e      <= cur_next;
    sorted_key <= out_key_next;
    sorted_tag <= out_tag_next;
    end_of_set <= out_end_next;
    overflowed <= out_ovf_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ovf_next       = ovf;
    n_next         = n;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    low_next       = low;
    min_next       = min_e;
    cur_next       = cur_e;
    out_valid_next = out_valid;
    out_key_next   = sorted_key;
    out_tag_next   = sorted_tag;
    out_end_next   = end_of_set;
    out_ovf_next   = overflowed;
    we             = 1'b0;
    waddr          = fill[AW-1:0];
    wdata          = '{key: key_value, tag: record_tag};
    raddr          = i[AW-1:0];

    unique case (state)
      rss_pkg::ST_LOAD: begin
        if (in_valid) begin
          // store the record or drop it when full
          if (fill < CAP) begin
            we        = 1'b1;
            fill_next = fill + ONE;
          end else begin
            ovf_next = 1'b1;
          end
          if (is_final) begin
            n_next = (fill < CAP) ? fill + ONE : fill;
            i_next = '0;
            k_next = '0;
            state_next = (n_next > ONE) ? rss_pkg::ST_ISSUE : rss_pkg::ST_EMIT_RD;
          end
        end
      end

      rss_pkg::ST_ISSUE: begin
        // read the entry at the pass position first
        raddr      = i[AW-1:0];
        j_next     = i + ONE;
        state_next = rss_pkg::ST_SCAN;
      end

      rss_pkg::ST_SCAN: begin
        // rdata holds entry j-1 while entry j is read
        raddr = j[AW-1:0];
        if (j == i + ONE) begin
          min_next = rdata;
          cur_next = rdata;
          low_next = i[AW-1:0];
        end else if (rdata.key < min_e.key) begin
          min_next = rdata;
          low_next = j_prev[AW-1:0];
        end
        if (j == n) begin
          state_next = rss_pkg::ST_SWAP_LOW;
        end else begin
          j_next = j + ONE;
        end
      end

      rss_pkg::ST_SWAP_LOW: begin
        // pass position entry goes to the minimum's slot
        we         = 1'b1;
        waddr      = low;
        wdata      = cur_e;
        state_next = rss_pkg::ST_SWAP_POS;
      end

      rss_pkg::ST_SWAP_POS: begin
        // minimum goes to the pass position
        we     = 1'b1;
        waddr  = i[AW-1:0];
        wdata  = min_e;
        i_next = i + ONE;
        if (i + ONE + ONE < n) begin
          state_next = rss_pkg::ST_ISSUE;
        end else begin
          state_next = rss_pkg::ST_EMIT_RD;
        end
      end

      rss_pkg::ST_EMIT_RD: begin
        raddr      = k[AW-1:0];
        state_next = rss_pkg::ST_EMIT_LD;
      end

      rss_pkg::ST_EMIT_LD: begin
        // load the output register
        raddr          = k[AW-1:0];
        out_key_next   = rdata.key;
        out_tag_next   = rdata.tag;
        out_end_next   = (k + ONE == n);
        out_ovf_next   = ovf;
        out_valid_next = 1'b1;
        state_next     = rss_pkg::ST_EMIT_HOLD;
      end

      rss_pkg::ST_EMIT_HOLD: begin
        raddr = k[AW-1:0];
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (k + ONE == n) begin
            // set done, start over empty
            fill_next  = '0;
            ovf_next   = 1'b0;
            state_next = rss_pkg::ST_LOAD;
          end else begin
            k_next     = k + ONE;
            state_next = rss_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = rss_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
